### src/ble_pkg.sv
// Shared types and codes for the bounded list engine.
// No dependencies; every other file in src imports this package.
package ble_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned LEN_W  = 5;
    localparam int unsigned STAT_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_REMOVE     = 3'd4,
        KIND_CONTAINS   = 3'd5
    } t_kind;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic                     found;
        logic [STAT_W-1:0]        status;
        logic [LEN_W-1:0]         length;
    } t_res;

endpackage

### src/ble_store.sv
// Entry store for the bounded list engine: one write port, one read port,
// read data registered. Depends on ble_pkg for the data width.
module ble_store
    import ble_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/bounded_list_engine_core.sv
// Top level of the bounded list engine: command sequencer, ring pointers
// and the shared compare/move step. Depends on ble_pkg and ble_store.
//
// The list lives in a ring of CAPACITY words with a head pointer, so pushes
// and pops at either end touch one word. A command word is taken at the edge
// where start is high and busy is low; exactly one result word follows on
// o_res, marked by o_strobe for one cycle, and the receiver cannot stall it.
// The cycle count is set by the single read port of the store and the one
// comparator that walks it: a push, a refused command or an unused kind
// raises the strobe in the cycle after acceptance and busy stays low; a pop
// keeps busy high while the registered store read completes. Contains keeps
// busy high while it scans up to the hit, and over the whole list on a
// miss. Remove-by-value keeps busy high while it walks the whole current
// list, whether it hits or not: the scan up to the hit, then one word moved
// per cycle to close the gap. A new command may be presented in the cycle
// the strobe is shown. The store needs no clearing after reset: only words
// below the length are ever used.
module bounded_list_engine_core
    import ble_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_strobe,
    output t_res o_res
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_SHIFT
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_head,  n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx,   n_idx;
    logic [KIND_W-1:0] r_kind,  n_kind;
    logic [DATA_W-1:0] r_val,   n_val;
    logic              r_strobe, n_strobe;
    t_res              r_res,   n_res;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic [CW:0]       idx_p1;
    logic [CW:0]       idx_p2;
    logic [CW:0]       count_w;
    logic              full;
    logic              empty;
    logic              hit;
    logic [AW-1:0]     head_dec;
    logic [AW-1:0]     head_inc;

    // Map a position in the list to a word of the ring.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW:0]   pos);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + pos;
        if (sum >= (CW+1)'(CAPACITY)) begin
            sum = sum - (CW+1)'(CAPACITY);
        end
        return AW'(sum);
    endfunction

    ble_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign idx_p1   = (CW+1)'(r_idx) + (CW+1)'(1);
    assign idx_p2   = (CW+1)'(r_idx) + (CW+1)'(2);
    assign count_w  = (CW+1)'(r_count);
    assign full     = (r_count == CW'(CAPACITY));
    assign empty    = (r_count == '0);
    // The shared compare step: word just read against the search value.
    assign hit      = (mem_rdata == r_val);
    assign head_dec = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - AW'(1);
    assign head_inc = (r_head == AW'(CAPACITY - 1)) ? '0 : r_head + AW'(1);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        n_kind    = r_kind;
        n_val     = r_val;
        n_strobe  = 1'b0;
        n_res     = '0;
        mem_we    = 1'b0;
        mem_waddr = r_head;
        mem_wdata = i_cmd.value;
        mem_raddr = phys(r_head, idx_p1);

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_kind = i_cmd.kind;
                    n_val  = i_cmd.value;
                    case (i_cmd.kind)
                        KIND_PUSH_FRONT: begin
                            n_strobe = 1'b1;
                            if (full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = head_dec;
                                n_head    = head_dec;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        KIND_PUSH_BACK: begin
                            n_strobe = 1'b1;
                            if (full) begin
                                n_res.status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = phys(r_head, count_w);
                                n_count   = r_count + CW'(1);
                            end
                        end
                        KIND_POP_FRONT: begin
                            if (empty) begin
                                n_strobe     = 1'b1;
                                n_res.status = ST_EMPTY;
                            end else begin
                                mem_raddr = r_head;
                                n_state   = S_POP;
                            end
                        end
                        KIND_POP_BACK: begin
                            if (empty) begin
                                n_strobe     = 1'b1;
                                n_res.status = ST_EMPTY;
                            end else begin
                                mem_raddr = phys(r_head, count_w - (CW+1)'(1));
                                n_state   = S_POP;
                            end
                        end
                        KIND_REMOVE, KIND_CONTAINS: begin
                            if (empty) begin
                                n_strobe = 1'b1;
                            end else begin
                                mem_raddr = r_head;
                                n_idx     = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end

            S_POP: begin
                n_res.popped_value = mem_rdata;
                if (r_kind == KIND_POP_FRONT) begin
                    n_head = head_inc;
                end
                n_count  = r_count - CW'(1);
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end

            S_SCAN: begin
                // Read of the next position is already issued by default.
                if (hit) begin
                    if (r_kind == KIND_REMOVE && idx_p1 < count_w) begin
                        n_state = S_SHIFT;
                    end else begin
                        if (r_kind == KIND_REMOVE) begin
                            n_count = r_count - CW'(1);
                        end
                        n_res.found = 1'b1;
                        n_strobe    = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (idx_p1 == count_w) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_idx = idx_p1[CW-1:0];
                end
            end

            S_SHIFT: begin
                // Move the word behind the gap forward one place.
                mem_we    = 1'b1;
                mem_waddr = phys(r_head, (CW+1)'(r_idx));
                mem_wdata = mem_rdata;
                mem_raddr = phys(r_head, idx_p2);
                if (idx_p2 == count_w) begin
                    n_count     = r_count - CW'(1);
                    n_res.found = 1'b1;
                    n_strobe    = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_idx = idx_p1[CW-1:0];
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_res.length = LEN_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_idx  <= n_idx;
        r_kind <= n_kind;
        r_val  <= n_val;
        r_res  <= n_res;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("list length beyond capacity");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= AW'(CAPACITY - 1))
        else $error("head pointer outside ring");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_strobe))
        else $error("accepted command produced neither work nor result");

    a_strobe_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(start) || $past(busy)))
        else $error("result strobe without a command");

    a_shift_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_count >= CW'(2)))
        else $error("gap close with fewer than two entries");
`endif

endmodule
